// ----- hw/rtl/rsst_pkg.sv -----
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared types, constants and helpers for the range spread sparse table.
// ----------------------------------------------------------------------------
package rsst_pkg;

    localparam int DEPTH       = 1024;
    localparam int LEVELS      = 11;
    localparam int VALUE_WIDTH = 32;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int K_W    = $clog2(CNT_W);
    localparam int ENTRIES = LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int SPAN_W = ((LEVELS + 1) > (CNT_W + 1)) ? (LEVELS + 1) : (CNT_W + 1);

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_QREAD,
        S_QCMP,
        S_QSUB
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic [9:0]         left_index;
        logic [10:0]        right_index;
    } t_in_item;

    typedef struct packed {
        logic [31:0] spread;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic    capture;
        logic    load_start;
        logic    load_step;
        logic    load_end;
        logic    q_prep;
        logic    q_read;
        logic    q_cmp;
        logic    clear;
        logic    reply;
        logic    reply_spread;
        t_status reply_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       step_ok;
        logic       q_bad;
    } t_dp_status;

    function automatic logic [K_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
        logic [K_W-1:0] k;
        k = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (x[i]) begin
                k = K_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [ADDR_W-1:0] slot(input logic [LVL_W-1:0] lvl,
                                                input logic [IDX_W-1:0] idx);
        return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(DEPTH)) + ADDR_W'(idx);
    endfunction

endpackage

// ----- hw/rtl/range_spread_sparse_table.sv -----
// ----------------------------------------------------------------------------
// range_spread_sparse_table
// Sparse-table engine returning max minus min over a half-open index range.
// ----------------------------------------------------------------------------
// a load writes level 0, then one level per step up to min(LEVELS-1, floor(log2(count+1)));
// a query checks the range, reads two entries per table, compares, then subtracts; a flagged
// range skips the reads; restart, load into a full table and unused action reply from decode
// one transaction at a time; busy is high until its result is issued
// synchronous reset clears the count and control; table contents are kept
// the receiver cannot stall: o_valid is high for exactly one cycle
module range_spread_sparse_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rsst_pkg::t_in_item  i_item,
    output logic                o_valid,
    output rsst_pkg::t_out_item o_result
);

    rsst_pkg::t_dp_cmd    dp_cmd;
    rsst_pkg::t_dp_status dp_status;

    rsst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    rsst_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != rsst_pkg::ST_OK)) |-> (o_result.spread == '0))
        else $error("nonzero spread on flagged transaction");

    a_reply_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.reply |=> !busy)
        else $error("controller busy after issuing a result");

endmodule

// ----- hw/rtl/rsst_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsst_ctrl
// Controller state machine: sequences loads, queries and restarts.
// ----------------------------------------------------------------------------
module rsst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rsst_pkg::t_dp_status i_status,
    output rsst_pkg::t_dp_cmd    o_cmd
);

    rsst_pkg::t_state r_state;
    rsst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.reply_status = rsst_pkg::ST_OK;
        case (r_state)
            rsst_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rsst_pkg::S_DECODE;
                end
            end
            rsst_pkg::S_DECODE: begin
                case (i_status.action)
                    rsst_pkg::ACT_LOAD: begin
                        if (i_status.full) begin
                            o_cmd.reply        = 1'b1;
                            o_cmd.reply_status = rsst_pkg::ST_FULL;
                            n_state            = rsst_pkg::S_IDLE;
                        end else begin
                            o_cmd.load_start = 1'b1;
                            n_state          = rsst_pkg::S_LOAD;
                        end
                    end
                    rsst_pkg::ACT_QUERY: begin
                        o_cmd.q_prep = 1'b1;
                        n_state      = rsst_pkg::S_QREAD;
                    end
                    rsst_pkg::ACT_RESTART: begin
                        o_cmd.clear = 1'b1;
                        o_cmd.reply = 1'b1;
                        n_state     = rsst_pkg::S_IDLE;
                    end
                    default: begin
                        o_cmd.reply = 1'b1;
                        n_state     = rsst_pkg::S_IDLE;
                    end
                endcase
            end
            rsst_pkg::S_LOAD: begin
                if (i_status.step_ok) begin
                    o_cmd.load_step = 1'b1;
                end else begin
                    o_cmd.load_end = 1'b1;
                    o_cmd.reply    = 1'b1;
                    n_state        = rsst_pkg::S_IDLE;
                end
            end
            rsst_pkg::S_QREAD: begin
                if (i_status.q_bad) begin
                    o_cmd.reply        = 1'b1;
                    o_cmd.reply_status = rsst_pkg::ST_BAD_RANGE;
                    n_state            = rsst_pkg::S_IDLE;
                end else begin
                    o_cmd.q_read = 1'b1;
                    n_state      = rsst_pkg::S_QCMP;
                end
            end
            rsst_pkg::S_QCMP: begin
                o_cmd.q_cmp = 1'b1;
                n_state     = rsst_pkg::S_QSUB;
            end
            rsst_pkg::S_QSUB: begin
                o_cmd.reply        = 1'b1;
                o_cmd.reply_spread = 1'b1;
                n_state            = rsst_pkg::S_IDLE;
            end
            default: begin
                n_state = rsst_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != rsst_pkg::S_IDLE);

endmodule

// ----- hw/rtl/rsst_dp.sv -----
// ----------------------------------------------------------------------------
// rsst_dp
// Datapath: min/max table memories, element count, level walk and query math.
// ----------------------------------------------------------------------------
module rsst_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsst_pkg::t_in_item   i_item,
    input  rsst_pkg::t_dp_cmd    i_cmd,
    output rsst_pkg::t_dp_status o_status,
    output logic                 o_valid,
    output rsst_pkg::t_out_item  o_result
);

    localparam int VW = rsst_pkg::VALUE_WIDTH;

    logic signed [VW-1:0] r_min_mem [rsst_pkg::ENTRIES];
    logic signed [VW-1:0] r_max_mem [rsst_pkg::ENTRIES];

    rsst_pkg::t_in_item              r_item;
    logic [rsst_pkg::CNT_W-1:0]      r_count;
    logic [rsst_pkg::LVL_W-1:0]      r_lvl;
    logic [rsst_pkg::K_W-1:0]        r_k;
    logic                            r_q_bad;
    logic signed [VW-1:0]            r_run_min;
    logic signed [VW-1:0]            r_run_max;
    logic signed [VW-1:0]            r_rda_min;
    logic signed [VW-1:0]            r_rda_max;
    logic signed [VW-1:0]            r_rdb_min;
    logic signed [VW-1:0]            r_rdb_max;
    logic signed [VW-1:0]            r_mn;
    logic signed [VW-1:0]            r_mx;
    logic                            r_valid;
    rsst_pkg::t_out_item             r_result;

    logic [rsst_pkg::SPAN_W-1:0]     span;
    logic [rsst_pkg::SPAN_W-1:0]     n_plus1;
    logic [rsst_pkg::IDX_W-1:0]      j_cur;
    logic [rsst_pkg::IDX_W-1:0]      j_next;
    logic [rsst_pkg::IDX_W-1:0]      n_idx;
    logic [rsst_pkg::CNT_W-1:0]      q_left;
    logic [rsst_pkg::CNT_W-1:0]      q_right;
    logic [rsst_pkg::CNT_W-1:0]      q_len;
    logic [rsst_pkg::K_W-1:0]        q_k;
    logic [rsst_pkg::LVL_W-1:0]      k_lvl;
    logic [rsst_pkg::CNT_W-1:0]      q_j2;
    logic                            mem_we;
    logic [rsst_pkg::ADDR_W-1:0]     wa;
    logic [rsst_pkg::ADDR_W-1:0]     ra_a;
    logic [rsst_pkg::ADDR_W-1:0]     ra_b;
    logic signed [VW-1:0]            wd_min;
    logic signed [VW-1:0]            wd_max;
    logic signed [VW-1:0]            step_min;
    logic signed [VW-1:0]            step_max;
    logic signed [VW-1:0]            ld_value;

    assign ld_value = VW'(r_item.value);
    assign n_idx    = rsst_pkg::IDX_W'(r_count);
    assign span     = rsst_pkg::SPAN_W'(1) << r_lvl;
    assign n_plus1  = rsst_pkg::SPAN_W'(r_count) + rsst_pkg::SPAN_W'(1);
    assign j_cur    = rsst_pkg::IDX_W'(n_plus1 - span);
    assign j_next   = rsst_pkg::IDX_W'(n_plus1 - (span << 1));

    assign step_min = (r_rda_min < r_run_min) ? r_rda_min : r_run_min;
    assign step_max = (r_rda_max > r_run_max) ? r_rda_max : r_run_max;

    assign q_left  = rsst_pkg::CNT_W'(r_item.left_index);
    assign q_right = rsst_pkg::CNT_W'(r_item.right_index);
    assign q_len   = q_right - q_left;
    assign q_k     = rsst_pkg::floor_log2(q_len);
    assign k_lvl   = rsst_pkg::LVL_W'(r_k);
    assign q_j2    = q_right - (rsst_pkg::CNT_W'(1) << r_k);

    always_comb begin
        mem_we = 1'b0;
        wa     = rsst_pkg::slot(rsst_pkg::LVL_W'(0), n_idx);
        wd_min = ld_value;
        wd_max = ld_value;
        ra_a   = rsst_pkg::slot(rsst_pkg::LVL_W'(0), n_idx - rsst_pkg::IDX_W'(1));
        ra_b   = rsst_pkg::slot(k_lvl, rsst_pkg::IDX_W'(q_j2));
        if (i_cmd.load_start) begin
            mem_we = 1'b1;
        end else if (i_cmd.load_step) begin
            mem_we = 1'b1;
            wa     = rsst_pkg::slot(r_lvl, j_cur);
            wd_min = step_min;
            wd_max = step_max;
            ra_a   = rsst_pkg::slot(r_lvl, j_next);
        end else if (i_cmd.q_read) begin
            ra_a   = rsst_pkg::slot(k_lvl, rsst_pkg::IDX_W'(q_left));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_min_mem[wa] <= wd_min;
        end
        r_rda_min <= r_min_mem[ra_a];
        r_rdb_min <= r_min_mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_max_mem[wa] <= wd_max;
        end
        r_rda_max <= r_max_mem[ra_a];
        r_rdb_max <= r_max_mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.reply;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load_end) begin
                r_count <= r_count + rsst_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.load_start) begin
            r_lvl     <= rsst_pkg::LVL_W'(1);
            r_run_min <= ld_value;
            r_run_max <= ld_value;
        end else if (i_cmd.load_step) begin
            r_lvl     <= r_lvl + rsst_pkg::LVL_W'(1);
            r_run_min <= step_min;
            r_run_max <= step_max;
        end
        if (i_cmd.q_prep) begin
            r_k     <= q_k;
            r_q_bad <= (q_left >= q_right) || (q_right > r_count) ||
                       (32'(q_k) >= rsst_pkg::LEVELS);
        end
        if (i_cmd.q_cmp) begin
            r_mn <= (r_rda_min < r_rdb_min) ? r_rda_min : r_rdb_min;
            r_mx <= (r_rda_max > r_rdb_max) ? r_rda_max : r_rdb_max;
        end
        if (i_cmd.reply) begin
            r_result.status <= i_cmd.reply_status;
            r_result.spread <= i_cmd.reply_spread ? 32'(r_mx - r_mn) : '0;
        end
    end

    always_comb begin
        o_status.action  = r_item.action;
        o_status.full    = (r_count == rsst_pkg::CNT_W'(rsst_pkg::DEPTH));
        o_status.step_ok = (32'(r_lvl) < rsst_pkg::LEVELS) && (span <= n_plus1);
        o_status.q_bad   = r_q_bad;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
